// File: src/soec_pkg.sv
// soec_pkg: shared constants, register indexes and payload types of the
// sobel orientation edge classifier; depends on nothing
package soec_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int HEIGHT_LIMIT      = 1024;
  localparam int DIM_FLOOR         = 8;
  localparam int THRESH_LOW        = 24;
  localparam int THRESH_HIGH       = 110;
  localparam int THRESH_RESET      = 64;
  localparam int DIM_RESET         = 1024;
  localparam int CFG_W             = 11;
  localparam int THRESH_W          = 7;
  localparam int COORD_W           = 10;
  localparam int GRAD_W            = 10;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } coord_t;

  typedef struct packed {
    logic [GRAD_W-1:0] right;
    logic [GRAD_W-1:0] left;
    logic [GRAD_W-1:0] lower;
    logic [GRAD_W-1:0] upper;
  } sums_t;

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [GRAD_W-1:0] weigh(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

endpackage

// File: src/soec_line_store.sv
// soec_line_store: the two line stores as one synchronous memory, each entry
// holding {older line, previous line}; registered read, one write port
module soec_line_store #(
  parameter int DEPTH = soec_pkg::MAX_WIDTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/soec_window.sv
// soec_window: window columns, line store write-back and the weighted sums
// stage; depends on soec_pkg
module soec_window (
  input  logic             clk,
  input  logic             rst,
  input  logic             s1_valid,
  input  logic             s1_emit,
  input  logic [7:0]       s1_pixel,
  input  soec_pkg::coord_t s1_coord,
  input  logic [15:0]      rd_data,
  output logic             advance,
  output logic [15:0]      wr_data,
  output logic             s2_valid,
  output soec_pkg::sums_t  s2_sums,
  output soec_pkg::coord_t s2_coord,
  input  logic             s2_ready
);

  logic [23:0] win0;
  logic [23:0] win1;
  logic [7:0]  top;
  logic [7:0]  mid;
  logic [23:0] cur;

  assign top     = rd_data[15:8];
  assign mid     = rd_data[7:0];
  assign cur     = {top, mid, s1_pixel};
  assign wr_data = {mid, s1_pixel};
  assign advance = s1_valid && (!s2_valid || s2_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      win0     <= '0;
      win1     <= '0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      win0     <= win1;
      win1     <= cur;
      s2_valid <= s1_emit;
    end else if (s2_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_coord      <= s1_coord;
      s2_sums.right <= soec_pkg::weigh(top, mid, s1_pixel);
      s2_sums.left  <= soec_pkg::weigh(win0[23:16], win0[15:8], win0[7:0]);
      s2_sums.lower <= soec_pkg::weigh(win0[7:0], win1[7:0], s1_pixel);
      s2_sums.upper <= soec_pkg::weigh(win0[23:16], win1[23:16], top);
    end
  end

endmodule

// File: src/soec_classify.sv
// soec_classify: absolute gradients, edge flags and the output word register;
// depends on soec_pkg
module soec_classify (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s2_valid,
  input  soec_pkg::sums_t                 s2_sums,
  input  soec_pkg::coord_t                s2_coord,
  output logic                            s2_ready,
  input  logic [soec_pkg::THRESH_W-1:0]   threshold,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [soec_pkg::COORD_W-1:0]    center_column,
  output logic [soec_pkg::COORD_W-1:0]    center_row,
  output logic                            horizontal_edge,
  output logic                            vertical_edge,
  output logic [soec_pkg::GRAD_W-1:0]     vertical_gradient,
  output logic [soec_pkg::GRAD_W-1:0]     horizontal_gradient
);

  logic                          s3_valid;
  logic                          s3_adv;
  logic [soec_pkg::GRAD_W-1:0]   s3_gx;
  logic [soec_pkg::GRAD_W-1:0]   s3_gy;
  soec_pkg::coord_t              s3_coord;
  logic [soec_pkg::GRAD_W:0]     gx2;
  logic [soec_pkg::GRAD_W:0]     gy2;
  logic [soec_pkg::GRAD_W-1:0]   t_ext;

  assign s3_adv   = s3_valid && (!out_valid || out_ready);
  assign s2_ready = !s3_valid || s3_adv;
  assign gx2      = {s3_gx, 1'b0};
  assign gy2      = {s3_gy, 1'b0};
  assign t_ext    = soec_pkg::GRAD_W'(threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_valid && s2_ready) begin
      s3_valid <= 1'b1;
    end else if (s3_adv) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      s3_coord <= s2_coord;
      s3_gx    <= (s2_sums.right >= s2_sums.left) ? s2_sums.right - s2_sums.left
                                                  : s2_sums.left - s2_sums.right;
      s3_gy    <= (s2_sums.lower >= s2_sums.upper) ? s2_sums.lower - s2_sums.upper
                                                   : s2_sums.upper - s2_sums.lower;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      center_column       <= s3_coord.column;
      center_row          <= s3_coord.row;
      vertical_gradient   <= s3_gy;
      horizontal_gradient <= s3_gx;
      horizontal_edge     <= (s3_gy > t_ext) && (gy2 >= {1'b0, s3_gx});
      vertical_edge       <= (s3_gx > t_ext) && (gx2 >= {1'b0, s3_gy});
    end
  end

endmodule

// File: src/sobel_orientation_edge_classifier_core.sv
// sobel_orientation_edge_classifier_core: raster counters, configuration and
// line store read stage; uses soec_pkg, soec_line_store, soec_window, soec_classify
// a result word is registered in turn in s1, s2, s3 and the output register after its completing pixel is taken
// throughput: one pixel word per cycle while out_ready holds no stage back; the line store
// memory is read for each taken pixel and written back as that pixel leaves s1
// reset: synchronous, clears counters, window and valid flags; registers
// return to width min(MAX_WIDTH, 1024), height 1024, threshold 64; line stores are not cleared
module sobel_orientation_edge_classifier_core #(
  parameter int MAX_WIDTH = soec_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_enable,
  input  logic [1:0]                     cfg_index,
  input  logic [soec_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [soec_pkg::COORD_W-1:0]   center_column,
  output logic [soec_pkg::COORD_W-1:0]   center_row,
  output logic                           horizontal_edge,
  output logic                           vertical_edge,
  output logic [soec_pkg::GRAD_W-1:0]    vertical_gradient,
  output logic [soec_pkg::GRAD_W-1:0]    horizontal_gradient
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int WWM  = $clog2(MAX_WIDTH + 1);
  localparam int WW   = (WWM > soec_pkg::CFG_W) ? WWM : soec_pkg::CFG_W;
  localparam int XWE  = (XW > soec_pkg::COORD_W) ? XW : soec_pkg::COORD_W;
  localparam int WRST = (MAX_WIDTH < soec_pkg::DIM_RESET) ? MAX_WIDTH : soec_pkg::DIM_RESET;
  localparam int HW   = soec_pkg::CFG_W;

  logic [WW-1:0]                   width_eff;
  logic [HW-1:0]                   height_eff;
  logic [soec_pkg::THRESH_W-1:0]   threshold;

  logic [XW-1:0]                   col;
  logic [soec_pkg::COORD_W-1:0]    row;
  logic [WW-1:0]                   col_ext;
  logic [WW-1:0]                   col_inc;
  logic [HW-1:0]                   row_ext;
  logic [HW-1:0]                   row_inc;
  logic [XW-1:0]                   col_dec;
  logic [XWE-1:0]                  col_dec_ext;
  logic                            accept;
  logic                            emit;

  logic                            s1_valid;
  logic                            s1_emit;
  logic [7:0]                      s1_pixel;
  logic [XW-1:0]                   s1_addr;
  soec_pkg::coord_t                s1_coord;
  logic                            s1_adv;

  logic [15:0]                     rd_data;
  logic [15:0]                     wr_data;
  logic                            s2_valid;
  logic                            s2_ready;
  soec_pkg::sums_t                 s2_sums;
  soec_pkg::coord_t                s2_coord;

  assign accept      = in_valid && in_ready;
  assign in_ready    = !s1_valid || s1_adv;
  assign col_ext     = WW'(col);
  assign col_inc     = col_ext + WW'(1);
  assign row_ext     = HW'(row);
  assign row_inc     = row_ext + HW'(1);
  assign col_dec     = col - XW'(1);
  assign col_dec_ext = XWE'(col_dec);
  assign emit        = (col_ext >= WW'(2)) && (row_ext >= HW'(2)) &&
                       (col_ext < width_eff) && (row_ext < height_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(WRST);
      height_eff <= HW'(soec_pkg::DIM_RESET);
      threshold  <= soec_pkg::THRESH_W'(soec_pkg::THRESH_RESET);
    end else if (cfg_write_enable) begin
      unique case (soec_pkg::reg_index_t'(cfg_index))
        soec_pkg::REG_IMAGE_WIDTH: begin
          width_eff <= WW'(soec_pkg::clamp_u(32'(cfg_data), soec_pkg::DIM_FLOOR, MAX_WIDTH));
        end
        soec_pkg::REG_IMAGE_HEIGHT: begin
          height_eff <= HW'(soec_pkg::clamp_u(32'(cfg_data), soec_pkg::DIM_FLOOR,
                                              soec_pkg::HEIGHT_LIMIT));
        end
        soec_pkg::REG_EDGE_THRESHOLD: begin
          threshold <= soec_pkg::THRESH_W'(soec_pkg::clamp_u(
                         32'(cfg_data[soec_pkg::THRESH_W-1:0]),
                         soec_pkg::THRESH_LOW, soec_pkg::THRESH_HIGH));
        end
        default: begin
        end
      endcase
    end
  end

  // raster position of the next pixel word
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_inc >= width_eff) begin
        col <= '0;
        row <= (row_inc >= height_eff) ? '0 : soec_pkg::COORD_W'(row_inc);
      end else begin
        col <= XW'(col_inc);
        if (row_ext >= height_eff) begin
          row <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit         <= emit;
      s1_pixel        <= pixel;
      s1_addr         <= col;
      s1_coord.column <= col_dec_ext[soec_pkg::COORD_W-1:0];
      s1_coord.row    <= row - soec_pkg::COORD_W'(1);
    end
  end

  soec_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr),
    .wr_data (wr_data)
  );

  soec_window u_window (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_emit  (s1_emit),
    .s1_pixel (s1_pixel),
    .s1_coord (s1_coord),
    .rd_data  (rd_data),
    .advance  (s1_adv),
    .wr_data  (wr_data),
    .s2_valid (s2_valid),
    .s2_sums  (s2_sums),
    .s2_coord (s2_coord),
    .s2_ready (s2_ready)
  );

  soec_classify u_classify (
    .clk                 (clk),
    .rst                 (rst),
    .s2_valid            (s2_valid),
    .s2_sums             (s2_sums),
    .s2_coord            (s2_coord),
    .s2_ready            (s2_ready),
    .threshold           (threshold),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .center_column       (center_column),
    .center_row          (center_row),
    .horizontal_edge     (horizontal_edge),
    .vertical_edge       (vertical_edge),
    .vertical_gradient   (vertical_gradient),
    .horizontal_gradient (horizontal_gradient)
  );

endmodule
